FILE: rtl/ecc_pkg.sv
// shared types, character codes and constants for the expression to stack code compiler
package ecc_pkg;

	localparam int MAX_DEPTH    = 10;
	localparam int OPERAND_BITS = 32;
	localparam int DEPTH_W      = $clog2(MAX_DEPTH);
	localparam int MAX_RESULTS  = 4;
	localparam int IDX_W        = $clog2(MAX_RESULTS);
	localparam int CNT_W        = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_Y     = 8'h79;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef enum logic [3:0] {
		OPC_PUSH_X     = 4'd0,
		OPC_PUSH_Y     = 4'd1,
		OPC_PUSH_CONST = 4'd2,
		OPC_ADD        = 4'd3,
		OPC_SUB        = 4'd4,
		OPC_MUL        = 4'd5,
		OPC_DIV        = 4'd6,
		OPC_GET_CELL   = 4'd7,
		OPC_END        = 4'd8,
		OPC_ERROR      = 4'd9
	} opcode_t;

	typedef enum logic [2:0] {
		PEND_NONE = 3'd0,
		PEND_ADD  = 3'd1,
		PEND_SUB  = 3'd2,
		PEND_MUL  = 3'd3,
		PEND_DIV  = 3'd4,
		PEND_CELL = 3'd5
	} pend_t;

	// results caused by one character, oldest in slot 0
	typedef struct packed {
		logic [CNT_W-1:0]                 cnt;
		opcode_t [MAX_RESULTS-1:0]        op;
		logic [OPERAND_BITS-1:0]          operand;
	} res_list_t;

	function automatic opcode_t pend_to_opc(input pend_t p);
		opcode_t o;
		case (p)
			PEND_ADD:  o = OPC_ADD;
			PEND_SUB:  o = OPC_SUB;
			PEND_MUL:  o = OPC_MUL;
			PEND_DIV:  o = OPC_DIV;
			PEND_CELL: o = OPC_GET_CELL;
			default:   o = OPC_ERROR;
		endcase
		return o;
	endfunction

endpackage

FILE: rtl/ecc_out_buf.sv
// result buffer that holds the results of one character and hands them out one per transfer
module ecc_out_buf
	import ecc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  res_list_t               list,
	output logic                    free,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [3:0]              opcode,
	output logic [OPERAND_BITS-1:0] operand,
	output logic                    last
);

	logic [CNT_W-1:0]          cnt_q;
	opcode_t [MAX_RESULTS-1:0] op_q;
	logic [OPERAND_BITS-1:0]   operand_q;
	logic                      xfer;

	assign res_valid = (cnt_q != '0);
	assign xfer      = res_valid && !res_stall;
	// room for a new list once the last held result goes out
	assign free      = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && !res_stall);
	assign opcode    = op_q[0];
	assign operand   = operand_q;
	assign last      = (cnt_q == CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= list.cnt;
		end else if (xfer) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q      <= list.op;
			operand_q <= list.operand;
		end else if (xfer) begin
			for (int i = 0; i < MAX_RESULTS - 1; i++) begin
				op_q[i] <= op_q[i+1];
			end
			op_q[MAX_RESULTS-1] <= OPC_PUSH_X;
			// only the first result can carry a constant
			operand_q <= '0;
		end
	end

endmodule

FILE: rtl/expression_to_stack_code_compiler_core.sv
// top level: character decode, expression state and result list build
// a transferred character is held in the input register, then its results load the output buffer once it is free
// throughput: one character per cycle when it causes at most one result and res_stall is low;
//   a character causing several results holds up the next one until the single result port drains the buffer
// at most three results per character occur in practice
// reset: arst_n asynchronously clears depth, pending operators, digit run and skip flag
module expression_to_stack_code_compiler_core
	import ecc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    ch_valid,
	output logic                    ch_stall,
	input  logic [7:0]              ch,
	output logic                    res_valid,
	input  logic                    res_stall,
	output logic [3:0]              opcode,
	output logic [OPERAND_BITS-1:0] operand,
	output logic                    last
);

	localparam int MAC_W = OPERAND_BITS + 4;

	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_X,
		CLS_Y,
		CLS_OP,
		CLS_OPEN,
		CLS_CLOSE,
		CLS_IGNORE,
		CLS_TERM
	} cls_t;

	logic [7:0]              ch_s1;
	logic                    valid_s1;
	logic                    take_s1;
	logic                    buf_free;

	logic [DEPTH_W-1:0]      depth_q;
	pend_t                   cur_q;
	pend_t                   lvl_q [MAX_DEPTH];
	logic                    in_num_q;
	logic [OPERAND_BITS-1:0] acc_q;
	logic                    skip_q;

	cls_t                    cls;
	pend_t                   op_code;
	logic [3:0]              dig;
	logic [MAC_W-1:0]        mac;
	logic [OPERAND_BITS-1:0] acc_sat;
	logic [DEPTH_W-1:0]      rd_idx;
	pend_t                   lvl_rd;

	logic [DEPTH_W-1:0]      nxt_depth;
	pend_t                   nxt_cur;
	pend_t                   cur_w;
	logic                    nxt_in_num;
	logic [OPERAND_BITS-1:0] nxt_acc;
	logic                    nxt_skip;
	logic                    lvl_we;
	logic                    clr;
	logic [CNT_W-1:0]        n;
	res_list_t               list;

	// input register
	assign take_s1  = valid_s1 && buf_free;
	assign ch_stall = valid_s1 && !buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ch_valid && !ch_stall) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ch_valid && !ch_stall) begin
			ch_s1 <= ch;
		end
	end

	// character decode
	always_comb begin
		op_code = PEND_NONE;
		case (ch_s1) inside
			[CH_0:CH_9]: cls = CLS_DIGIT;
			CH_X:        cls = CLS_X;
			CH_Y:        cls = CLS_Y;
			CH_PLUS: begin
				cls     = CLS_OP;
				op_code = PEND_ADD;
			end
			CH_MINUS: begin
				cls     = CLS_OP;
				op_code = PEND_SUB;
			end
			CH_STAR: begin
				cls     = CLS_OP;
				op_code = PEND_MUL;
			end
			CH_SLASH: begin
				cls     = CLS_OP;
				op_code = PEND_DIV;
			end
			CH_COMMA: begin
				cls     = CLS_OP;
				op_code = PEND_CELL;
			end
			CH_OPEN:            cls = CLS_OPEN;
			CH_CLOSE:           cls = CLS_CLOSE;
			CH_SPACE, CH_COLON: cls = CLS_IGNORE;
			default:            cls = CLS_TERM;
		endcase
	end

	// decimal accumulate, saturating
	assign dig     = 4'(ch_s1 - CH_0);
	assign mac     = MAC_W'({acc_q, 3'b000}) + MAC_W'({acc_q, 1'b0}) + MAC_W'(dig);
	assign acc_sat = (mac[MAC_W-1 -: 4] != 4'b0000) ? '1 : mac[OPERAND_BITS-1:0];

	// one read of the saved levels: the level above for an open, below for a close
	always_comb begin
		if (cls == CLS_OPEN) begin
			rd_idx = depth_q + DEPTH_W'(1);
		end else begin
			rd_idx = depth_q - DEPTH_W'(1);
		end
		if (32'(rd_idx) < MAX_DEPTH) begin
			lvl_rd = lvl_q[rd_idx];
		end else begin
			lvl_rd = PEND_NONE;
		end
	end

	// next state and result list
	always_comb begin
		nxt_depth  = depth_q;
		nxt_in_num = in_num_q;
		nxt_acc    = acc_q;
		nxt_skip   = skip_q;
		cur_w      = cur_q;
		lvl_we     = 1'b0;
		clr        = 1'b0;
		n          = '0;
		list       = '0;

		if (skip_q) begin
			if (cls == CLS_TERM) begin
				nxt_skip = 1'b0;
				clr      = 1'b1;
			end
		end else if (cls == CLS_DIGIT) begin
			nxt_in_num = 1'b1;
			nxt_acc    = in_num_q ? acc_sat : OPERAND_BITS'(dig);
		end else begin
			// a non-digit closes an open digit run first
			if (in_num_q) begin
				list.op[n[IDX_W-1:0]] = OPC_PUSH_CONST;
				list.operand          = acc_q;
				n                     = n + CNT_W'(1);
				nxt_in_num            = 1'b0;
				nxt_acc               = '0;
				if (cur_w != PEND_NONE) begin
					list.op[n[IDX_W-1:0]] = pend_to_opc(cur_w);
					n                     = n + CNT_W'(1);
					cur_w                 = PEND_NONE;
				end
			end
			case (cls)
				CLS_X, CLS_Y: begin
					list.op[n[IDX_W-1:0]] = (cls == CLS_X) ? OPC_PUSH_X : OPC_PUSH_Y;
					n                     = n + CNT_W'(1);
					if (cur_w != PEND_NONE) begin
						list.op[n[IDX_W-1:0]] = pend_to_opc(cur_w);
						n                     = n + CNT_W'(1);
						cur_w                 = PEND_NONE;
					end
				end
				CLS_OP: begin
					cur_w = op_code;
				end
				CLS_OPEN: begin
					if (depth_q == DEPTH_W'(MAX_DEPTH - 1)) begin
						list.op[n[IDX_W-1:0]] = OPC_ERROR;
						n                     = n + CNT_W'(1);
						clr                   = 1'b1;
						nxt_skip              = 1'b1;
					end else begin
						lvl_we    = 1'b1;
						nxt_depth = depth_q + DEPTH_W'(1);
					end
				end
				CLS_CLOSE: begin
					if (depth_q == '0) begin
						list.op[n[IDX_W-1:0]] = OPC_ERROR;
						n                     = n + CNT_W'(1);
						clr                   = 1'b1;
						nxt_skip              = 1'b1;
					end else begin
						lvl_we    = 1'b1;
						nxt_depth = depth_q - DEPTH_W'(1);
						if (lvl_rd != PEND_NONE) begin
							list.op[n[IDX_W-1:0]] = pend_to_opc(lvl_rd);
							n                     = n + CNT_W'(1);
						end
					end
				end
				CLS_TERM: begin
					list.op[n[IDX_W-1:0]] = OPC_END;
					n                     = n + CNT_W'(1);
					clr                   = 1'b1;
				end
				default: begin
				end
			endcase
		end

		list.cnt = n;

		// current level operator after an open comes from the saved entry; after a close it is cleared
		if (lvl_we) begin
			nxt_cur = (cls == CLS_OPEN) ? lvl_rd : PEND_NONE;
		end else begin
			nxt_cur = cur_w;
		end

		if (clr) begin
			nxt_depth  = '0;
			nxt_cur    = PEND_NONE;
			nxt_in_num = 1'b0;
			nxt_acc    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= '0;
			cur_q    <= PEND_NONE;
			in_num_q <= 1'b0;
			acc_q    <= '0;
			skip_q   <= 1'b0;
			for (int i = 0; i < MAX_DEPTH; i++) begin
				lvl_q[i] <= PEND_NONE;
			end
		end else if (take_s1) begin
			depth_q  <= nxt_depth;
			cur_q    <= nxt_cur;
			in_num_q <= nxt_in_num;
			acc_q    <= nxt_acc;
			skip_q   <= nxt_skip;
			if (clr) begin
				for (int i = 0; i < MAX_DEPTH; i++) begin
					lvl_q[i] <= PEND_NONE;
				end
			end else if (lvl_we) begin
				// save the leaving level's operator
				lvl_q[depth_q] <= cur_w;
			end
		end
	end

	ecc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take_s1 && (list.cnt != '0)),
		.list      (list),
		.free      (buf_free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.opcode    (opcode),
		.operand   (operand),
		.last      (last)
	);

endmodule

FILE: tb/tb.sv
// self-checking testbench for the expression to stack code compiler core
`timescale 1ns / 100ps

module tb;
	import ecc_pkg::*;

	localparam int RANDOM_ITEMS = 470;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int MAX_PRINTS   = 30;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    ch_valid  = 1'b0;
	logic [7:0]              ch        = 8'h00;
	logic                    res_stall = 1'b0;
	logic                    ch_stall;
	logic                    res_valid;
	logic [3:0]              opcode;
	logic [OPERAND_BITS-1:0] operand;
	logic                    last;

	// holds the expected instruction stream and the compiler state that produces it
	class stack_code_scoreboard;
		typedef struct {
			opcode_t                 op;
			logic [OPERAND_BITS-1:0] val;
			bit                      fin;
		} instr_t;

		instr_t                  expected_q[$];
		instr_t                  step_q[$];
		int unsigned             depth;
		pend_t                   pend_ops[MAX_DEPTH];
		bit                      in_num;
		logic [OPERAND_BITS-1:0] num_acc;
		bit                      skip;
		int                      errors;

		function new();
			clear_expr();
			skip   = 1'b0;
			errors = 0;
		endfunction

		static function bit is_formula_char(logic [7:0] c);
			return (c >= CH_0 && c <= CH_9) || c inside {CH_X, CH_Y, CH_COMMA, CH_CLOSE,
				CH_OPEN, CH_MINUS, CH_PLUS, CH_SLASH, CH_STAR, CH_COLON, CH_SPACE};
		endfunction

		function void clear_expr();
			depth   = 0;
			in_num  = 1'b0;
			num_acc = '0;
			foreach (pend_ops[i])
				pend_ops[i] = PEND_NONE;
		endfunction

		function void add(opcode_t o, logic [OPERAND_BITS-1:0] v);
			instr_t e;
			e.op  = o;
			e.val = v;
			e.fin = 1'b0;
			step_q.push_back(e);
		endfunction

		// pending operator of the current level goes out after its operand
		function void flush_pending();
			if (pend_ops[depth] != PEND_NONE) begin
				add(opcode_t'({1'b0, pend_ops[depth]} + 4'd2), '0);
				pend_ops[depth] = PEND_NONE;
			end
		endfunction

		function void fail_expr();
			add(OPC_ERROR, '0);
			clear_expr();
			skip = 1'b1;
		endfunction

		function void note_char(logic [7:0] c);
			bit         is_digit;
			logic [63:0] grown;
			logic [63:0] sat_max;
			sat_max  = (64'd1 << OPERAND_BITS) - 64'd1;
			is_digit = c >= CH_0 && c <= CH_9;
			step_q.delete();
			if (skip) begin
				if (!is_formula_char(c)) begin
					skip = 1'b0;
					clear_expr();
				end
				return;
			end
			if (is_digit) begin
				grown = (in_num ? 64'(num_acc) * 64'd10 : 64'd0) + 64'(c - CH_0);
				num_acc = (grown > sat_max) ? {OPERAND_BITS{1'b1}} : grown[OPERAND_BITS-1:0];
				in_num  = 1'b1;
				return;
			end
			if (in_num) begin
				add(OPC_PUSH_CONST, num_acc);
				in_num  = 1'b0;
				num_acc = '0;
				flush_pending();
			end
			case (c)
				CH_X: begin
					add(OPC_PUSH_X, '0);
					flush_pending();
				end
				CH_Y: begin
					add(OPC_PUSH_Y, '0);
					flush_pending();
				end
				CH_PLUS:  pend_ops[depth] = PEND_ADD;
				CH_MINUS: pend_ops[depth] = PEND_SUB;
				CH_STAR:  pend_ops[depth] = PEND_MUL;
				CH_SLASH: pend_ops[depth] = PEND_DIV;
				CH_COMMA: pend_ops[depth] = PEND_CELL;
				CH_OPEN: begin
					if (depth + 1 >= MAX_DEPTH)
						fail_expr();
					else
						depth++;
				end
				CH_CLOSE: begin
					if (depth == 0) begin
						fail_expr();
					end else begin
						depth--;
						flush_pending();
					end
				end
				CH_SPACE, CH_COLON: ;
				default: begin
					add(OPC_END, '0);
					clear_expr();
				end
			endcase
			if (step_q.size() > 0)
				step_q[step_q.size()-1].fin = 1'b1;
			foreach (step_q[i])
				expected_q.push_back(step_q[i]);
		endfunction

		task report_mismatch(string msg);
			if (errors < MAX_PRINTS)
				$display("[%0t] error: %s", $time, msg);
			errors++;
		endtask

		task check_result(logic [3:0] op, logic [OPERAND_BITS-1:0] val, logic fin);
			instr_t e;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected instruction op=%0d operand=%0d", op, val));
				return;
			end
			e = expected_q.pop_front();
			if (op !== e.op)
				report_mismatch($sformatf("opcode %0d, wanted %0d", op, e.op));
			if (val !== e.val)
				report_mismatch($sformatf("operand %0d, wanted %0d (op %0d)", val, e.val, e.op));
			if (fin !== e.fin)
				report_mismatch($sformatf("last %0b, wanted %0b (op %0d)", fin, e.fin, e.op));
		endtask
	endclass

	stack_code_scoreboard sb = new();

	logic [7:0] char_q[$];
	int         sent_cnt = 0;
	int         cycle_cnt = 0;
	bit         quiet = 1'b0;
	int         stall_left = 0;

	expression_to_stack_code_compiler_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ch_valid  (ch_valid),
		.ch_stall  (ch_stall),
		.ch        (ch),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.opcode    (opcode),
		.operand   (operand),
		.last      (last)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("expression_to_stack_code_compiler_core: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result(opcode, operand, last);
	end

	// receiver backpressure: bursts of stall, mostly short, some long
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (quiet || !arst_n) begin
			res_stall  <= 1'b0;
			stall_left <= $urandom_range(1, 8);
		end else if ($urandom_range(0, 2) == 0) begin
			res_stall  <= 1'b1;
			stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 3)
				: $urandom_range(10, 40);
		end else begin
			res_stall  <= 1'b0;
			stall_left <= $urandom_range(0, 6);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] pick_terminator();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (stack_code_scoreboard::is_formula_char(c))
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic logic [7:0] pick_formula_char();
		case ($urandom_range(0, 7))
			0: return CH_OPEN;
			1: return CH_CLOSE;
			2: return CH_X;
			3: return CH_Y;
			4: return ($urandom_range(0, 1) == 0) ? CH_SPACE : CH_COLON;
			5: return ($urandom_range(0, 1) == 0) ? CH_PLUS : CH_COMMA;
			6: return ($urandom_range(0, 1) == 0) ? CH_STAR : CH_SLASH;
			default: return ($urandom_range(0, 3) == 0) ? CH_MINUS
				: 8'(CH_0 + $urandom_range(0, 9));
		endcase
	endfunction

	task automatic put_ch(input logic [7:0] c);
		char_q.push_back(c);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put_ch(s[i]);
	endtask

	task automatic put_operand();
		int digits;
		case ($urandom_range(0, 2))
			0: put_ch(CH_X);
			1: put_ch(CH_Y);
			default: begin
				digits = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(4, 12);
				repeat (digits)
					put_ch(8'(CH_0 + $urandom_range(0, 9)));
			end
		endcase
	endtask

	task automatic put_op();
		if ($urandom_range(0, 9) == 0)
			put_ch(($urandom_range(0, 1) == 0) ? CH_SPACE : CH_COLON);
		case ($urandom_range(0, 4))
			0: put_ch(CH_PLUS);
			1: put_ch(CH_MINUS);
			2: put_ch(CH_STAR);
			3: put_ch(CH_SLASH);
			default: put_ch(CH_COMMA);
		endcase
		if ($urandom_range(0, 9) == 0)
			put_ch(CH_SPACE);
	endtask

	// well-formed formula; open_bias sets how eagerly it nests
	task automatic build_formula(input int open_bias);
		int lvl;
		int terms;
		lvl   = 0;
		terms = $urandom_range(1, 6);
		for (int t = 0; t < terms; t++) begin
			while (lvl < MAX_DEPTH - 1 && $urandom_range(0, 99) < open_bias) begin
				put_ch(CH_OPEN);
				lvl++;
			end
			put_operand();
			while (lvl > 0 && $urandom_range(0, 2) == 0) begin
				put_ch(CH_CLOSE);
				lvl--;
			end
			if (t < terms - 1)
				put_op();
		end
		while (lvl > 0) begin
			put_ch(CH_CLOSE);
			lvl--;
		end
		put_ch(pick_terminator());
	endtask

	// nesting past the bound, then characters that are dropped until the terminator
	task automatic build_too_deep();
		repeat (MAX_DEPTH)
			put_ch(CH_OPEN);
		repeat ($urandom_range(0, 5))
			put_ch(pick_formula_char());
		put_ch(pick_terminator());
	endtask

	task automatic build_broken();
		repeat ($urandom_range(3, 15))
			put_ch(pick_formula_char());
		put_ch(pick_terminator());
	endtask

	task automatic build_noise();
		repeat ($urandom_range(2, 10))
			put_ch(8'($urandom_range(0, 255)));
	endtask

	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			ch_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ch_valid <= 1'b1;
		ch       <= c;
		@(posedge clk);
		while (ch_stall)
			@(posedge clk);
		// transfer happened at this edge
		sb.note_char(c);
		sent_cnt++;
	endtask

	task automatic send_queued();
		while (char_q.size() > 0)
			send_char(char_q.pop_front());
	endtask

	task automatic wait_drained();
		ch_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int seq_idx;
		int kind;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		put_str("(x+9999999999)-y*7/x,5");
		put_ch(8'h00);
		put_ch(CH_CLOSE);
		put_ch(CH_SPACE);
		put_ch(8'hff);
		send_queued();
		wait_drained();

		sent_cnt = 0;
		seq_idx  = 0;
		while (sent_cnt < RANDOM_ITEMS) begin
			quiet = (seq_idx % 30) >= 24;
			kind  = $urandom_range(0, 99);
			if (seq_idx == 0 || kind < 8)
				build_too_deep();
			else if (kind < 16)
				build_formula(85);
			else if (kind < 80)
				build_formula(20);
			else if (kind < 92)
				build_broken();
			else
				build_noise();
			send_queued();
			if (seq_idx % 25 == 12)
				wait_drained();
			seq_idx++;
		end
		quiet = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("expression_to_stack_code_compiler_core: match");
		else
			$display("expression_to_stack_code_compiler_core: mismatch");
		$finish;
	end

endmodule
